### src/qle_pkg.sv
package qle_pkg;

    localparam int ACTIONS        = 4;
    localparam int ACT_BITS       = 2;
    localparam int STATE_IDX_BITS = 12;
    localparam int REWARD_BITS    = 32;
    localparam int VALUE_OUT_BITS = 32;
    localparam int COEF_BITS      = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [COEF_BITS-1:0] LEARNING_RATE_RESET = 16'd6554;
    localparam logic [COEF_BITS-1:0] DISCOUNT_RESET      = 16'd52429;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARNING_RATE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DISCOUNT      = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic [STATE_IDX_BITS-1:0]     state_index;
        logic [ACT_BITS-1:0]           action_taken;
        logic signed [REWARD_BITS-1:0] reward;
        logic [STATE_IDX_BITS-1:0]     next_state_index;
        logic [ACTIONS-1:0]            allowed_moves;
    } request_t;

    typedef struct packed {
        logic signed [VALUE_OUT_BITS-1:0] value_out;
        logic [ACT_BITS-1:0]              best_action;
        logic                             no_move_open;
        logic                             saturated;
    } result_t;

endpackage

### src/tabular_q_learning_engine.sv
// Channel   Handshake                    Payload
// request   start / busy                 request (qle_pkg::request_t)
// result    done, one-cycle strobe       result (qle_pkg::result_t)
// config    cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A select request keeps busy high through one row read and a four-step compare scan over
// the row; an update adds a second row read, two passes through the
// shared 17 x (VALUE_BITS+3..) multiplier, a subtract step and the row write-back.
// done pulses in the same cycle that busy falls; a new request is taken in that same cycle.
// After reset a clearing pass zeroes all 2^STATE_BITS rows, one row per cycle, with busy high;
// config writes are taken at any time. The receiver cannot stall, so nothing waits on it.
module tabular_q_learning_engine #(
    parameter int STATE_BITS = 12,
    parameter int VALUE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  qle_pkg::request_t                    request,
    output logic                                 done,
    output qle_pkg::result_t                     result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qle_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [qle_pkg::COEF_BITS-1:0]        cfg_data
);
    import qle_pkg::*;

    localparam int ROWS     = 1 << STATE_BITS;
    localparam int ROW_BITS = ACTIONS * VALUE_BITS;
    // target = reward + floor(discount * maxQ / 2^16), diff = target - Q
    localparam int TW = ((VALUE_BITS + 1 > REWARD_BITS) ? VALUE_BITS + 1 : REWARD_BITS) + 1;
    localparam int DW = TW + 1;
    localparam int PW = DW + COEF_BITS + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_A,
        ST_SCAN,
        ST_READ_B,
        ST_DIFF,
        ST_MUL,
        ST_WRITE
    } state_t;

    // control
    state_t                  state_reg, state_next;
    logic [STATE_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ACT_BITS-1:0]     scan_idx_reg, scan_idx_next;
    logic                    found_reg, found_next;
    logic                    done_reg, done_next;
    logic [COEF_BITS-1:0]    learning_rate_reg, learning_rate_next;
    logic [COEF_BITS-1:0]    discount_reg, discount_next;

    // datapath
    request_t                req_reg, req_next;
    result_t                 result_reg, result_next;
    logic signed [VALUE_BITS-1:0] best_val_reg, best_val_next;
    logic [ACT_BITS-1:0]     best_act_reg, best_act_next;
    logic signed [VALUE_BITS-1:0] q_reg, q_next;
    logic signed [DW-1:0]    diff_reg, diff_next;
    logic signed [PW-1:0]    prod_reg, prod_next;

    // shared multiplier
    logic signed [COEF_BITS:0] mul_a;
    logic signed [DW-1:0]      mul_b;
    logic signed [PW-1:0]      mul_prod;

    // table memory, one row of ACTIONS values per state
    logic [ROW_BITS-1:0]     mem [ROWS];
    logic [ROW_BITS-1:0]     rd_row_reg;
    logic                    mem_re;
    logic                    mem_we;
    logic [STATE_BITS-1:0]   mem_raddr;
    logic [STATE_BITS-1:0]   mem_waddr;
    logic [ROW_BITS-1:0]     mem_wdata;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;
    assign mul_prod  = mul_a * mul_b;

    always_comb
    begin
        logic [ACTIONS-1:0]           mask;
        logic signed [VALUE_BITS-1:0] slot_val;
        logic                         take;
        logic signed [VALUE_BITS-1:0] cand_val;
        logic [ACT_BITS-1:0]          cand_act;
        logic                         cand_found;
        logic signed [VALUE_BITS-1:0] q_cur;
        logic signed [TW-1:0]         target;
        logic signed [DW:0]           nv_wide;
        logic [DW-VALUE_BITS+1:0]     nv_hi;
        logic signed [VALUE_BITS-1:0] nv;
        logic                         sat;

        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        scan_idx_next      = scan_idx_reg;
        found_next         = found_reg;
        done_next          = 1'b0;
        learning_rate_next = learning_rate_reg;
        discount_next      = discount_reg;
        req_next           = req_reg;
        result_next        = result_reg;
        best_val_next      = best_val_reg;
        best_act_next      = best_act_reg;
        q_next             = q_reg;
        diff_next          = diff_reg;
        prod_next          = prod_reg;
        mul_a              = '0;
        mul_b              = '0;
        mem_re             = 1'b0;
        mem_we             = 1'b0;
        mem_raddr          = '0;
        mem_waddr          = '0;
        mem_wdata          = '0;

        mask = (req_reg.operation == OP_SELECT) ? req_reg.allowed_moves : '1;
        slot_val = $signed(rd_row_reg[scan_idx_reg * VALUE_BITS +: VALUE_BITS]);
        take = mask[scan_idx_reg] && (!found_reg || (slot_val > best_val_reg));
        cand_val   = take ? slot_val : best_val_reg;
        cand_act   = take ? scan_idx_reg : best_act_reg;
        cand_found = found_reg | take;

        q_cur   = $signed(rd_row_reg[req_reg.action_taken * VALUE_BITS +: VALUE_BITS]);
        target  = TW'($signed(req_reg.reward)) + TW'(prod_reg >>> COEF_BITS);
        nv_wide = (DW + 1)'(prod_reg >>> COEF_BITS) + (DW + 1)'(q_reg);
        nv_hi   = nv_wide[DW:VALUE_BITS-1];
        sat     = !((&nv_hi) || !(|nv_hi));
        if (!sat)
        begin
            nv = nv_wide[VALUE_BITS-1:0];
        end
        else if (nv_wide[DW])
        begin
            nv = {1'b1, {(VALUE_BITS - 1){1'b0}}};
        end
        else
        begin
            nv = {1'b0, {(VALUE_BITS - 1){1'b1}}};
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEARNING_RATE: learning_rate_next = cfg_data;
                CFG_DISCOUNT:      discount_next      = cfg_data;
                default:           ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = ST_READ_A;
                end
            end
            ST_READ_A:
            begin
                // select scans its own row, update scans the next state's row
                mem_re        = 1'b1;
                mem_raddr     = (req_reg.operation == OP_SELECT) ?
                                STATE_BITS'(req_reg.state_index) :
                                STATE_BITS'(req_reg.next_state_index);
                scan_idx_next = '0;
                found_next    = 1'b0;
                best_val_next = '0;
                best_act_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                best_val_next = cand_val;
                best_act_next = cand_act;
                found_next    = cand_found;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == ACT_BITS'(ACTIONS - 1))
                begin
                    if (req_reg.operation == OP_SELECT)
                    begin
                        result_next.value_out    = VALUE_OUT_BITS'(cand_val);
                        result_next.best_action  = cand_act;
                        result_next.no_move_open = !cand_found;
                        result_next.saturated    = 1'b0;
                        done_next                = 1'b1;
                        state_next               = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ_B;
                    end
                end
            end
            ST_READ_B:
            begin
                mem_re     = 1'b1;
                mem_raddr  = STATE_BITS'(req_reg.state_index);
                mul_a      = $signed({1'b0, discount_reg});
                mul_b      = DW'(best_val_reg);
                prod_next  = mul_prod;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                q_next     = q_cur;
                diff_next  = DW'(target) - DW'(q_cur);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mul_a      = $signed({1'b0, learning_rate_reg});
                mul_b      = diff_reg;
                prod_next  = mul_prod;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = STATE_BITS'(req_reg.state_index);
                mem_wdata = rd_row_reg;
                mem_wdata[req_reg.action_taken * VALUE_BITS +: VALUE_BITS] = nv;
                result_next.value_out    = VALUE_OUT_BITS'(nv);
                result_next.best_action  = '0;
                result_next.no_move_open = 1'b0;
                result_next.saturated    = sat;
                done_next                = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            scan_idx_reg      <= '0;
            found_reg         <= 1'b0;
            done_reg          <= 1'b0;
            learning_rate_reg <= LEARNING_RATE_RESET;
            discount_reg      <= DISCOUNT_RESET;
            result_reg        <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            scan_idx_reg      <= scan_idx_next;
            found_reg         <= found_next;
            done_reg          <= done_next;
            learning_rate_reg <= learning_rate_next;
            discount_reg      <= discount_next;
            result_reg        <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        best_val_reg <= best_val_next;
        best_act_reg <= best_act_next;
        q_reg        <= q_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_row_reg <= mem[mem_raddr];
        end
    end

endmodule
